[design/wbps_pkg.sv]
// Shared types, constants and register codes of the wildcard byte pattern scan unit.
package wbps_pkg;

    localparam int DATA_W            = 8;
    localparam int OFFSET_W          = 32;
    localparam int COUNT_W           = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int LEN_FIELD_W       = 6;
    localparam int PAT_WORDS         = 4;
    localparam int BYTES_PER_WORD    = 8;
    localparam int PAT_BYTES         = PAT_WORDS * BYTES_PER_WORD;
    localparam int MAX_PATTERN_DEF   = 32;
    localparam int POSITION_BITS_DEF = 32;

    localparam logic [DATA_W-1:0] WILDCARD = 8'h00;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_OCC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES3 = 3'd5;

    // One result item.
    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } wbps_result_t;

endpackage

[design/wbps_cfg.sv]
// Configuration registers and the length-aligned copy of the pattern.
module wbps_cfg
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int LEN_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data,
    output logic [LEN_W-1:0]                     len_m1,
    output logic [COUNT_W-1:0]                   target,
    output logic [MAX_PATTERN-1:0][DATA_W-1:0]   aligned_pat
);

    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]     pat_words_reg;
    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0]     pat_words_next;
    logic [LEN_W-1:0]                         len_m1_reg;
    logic [LEN_W-1:0]                         len_m1_next;
    logic [COUNT_W-1:0]                       target_reg;
    logic [COUNT_W-1:0]                       target_next;
    logic [MAX_PATTERN-1:0][DATA_W-1:0]       aligned_reg;
    logic [MAX_PATTERN-1:0][DATA_W-1:0]       aligned_next;
    logic [PAT_BYTES-1:0][DATA_W-1:0]         bytes_next;
    logic [LEN_FIELD_W:0]                     eff_len;
    logic                                     wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // Register file update; the effective length is clamped to 1..MAX_PATTERN.
    always_comb
    begin
        pat_words_next = pat_words_reg;
        target_next    = target_reg;
        eff_len        = (LEN_FIELD_W + 1)'(len_m1_reg) + 1'b1;
        case (cfg_index)
            REG_PATTERN_LEN:
            begin
                eff_len = {1'b0, cfg_data[LEN_FIELD_W-1:0]};
                if (eff_len == '0)
                begin
                    eff_len = (LEN_FIELD_W + 1)'(1);
                end
                else if (eff_len > (LEN_FIELD_W + 1)'(MAX_PATTERN))
                begin
                    eff_len = (LEN_FIELD_W + 1)'(MAX_PATTERN);
                end
            end
            REG_TARGET_OCC:     target_next       = cfg_data[COUNT_W-1:0];
            REG_PATTERN_BYTES0: pat_words_next[0] = cfg_data;
            REG_PATTERN_BYTES1: pat_words_next[1] = cfg_data;
            REG_PATTERN_BYTES2: pat_words_next[2] = cfg_data;
            REG_PATTERN_BYTES3: pat_words_next[3] = cfg_data;
            default:            ;
        endcase
        len_m1_next = LEN_W'(eff_len - 1'b1);
    end

    // Reorder the pattern so that entry k lines up with window entry k
    // (newest byte at 0); entries past the length become wildcards.
    always_comb
    begin
        bytes_next = pat_words_next;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k <= int'(len_m1_next))
            begin
                aligned_next[k] = bytes_next[5'(int'(len_m1_next) - k)];
            end
            else
            begin
                aligned_next[k] = WILDCARD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_words_reg <= '0;
            len_m1_reg    <= '0;
            target_reg    <= COUNT_W'(1);
            aligned_reg   <= '0;
        end
        else if (wr_en)
        begin
            pat_words_reg <= pat_words_next;
            len_m1_reg    <= len_m1_next;
            target_reg    <= target_next;
            aligned_reg   <= aligned_next;
        end
    end

    assign len_m1      = len_m1_reg;
    assign target      = target_reg;
    assign aligned_pat = aligned_reg;

endmodule

[design/wbps_scan.sv]
// Byte window, region state and the parallel wildcard comparison.
module wbps_scan
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int LEN_W         = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_fire,
    input  logic [DATA_W-1:0]                    data_byte,
    input  logic                                 end_of_region,
    input  logic [LEN_W-1:0]                     len_m1,
    input  logic [COUNT_W-1:0]                   target,
    input  logic [MAX_PATTERN-1:0][DATA_W-1:0]   aligned_pat,
    output logic                                 res_valid,
    output wbps_result_t                         res
);

    logic [MAX_PATTERN-1:0][DATA_W-1:0] window_reg;
    logic [MAX_PATTERN-1:0][DATA_W-1:0] window_next;
    logic [POSITION_BITS-1:0]           pos_reg;
    logic [POSITION_BITS-1:0]           pos_next;
    logic [COUNT_W-1:0]                 count_reg;
    logic [COUNT_W-1:0]                 count_next;
    logic [COUNT_W-1:0]                 count_inc;
    logic [LEN_W-1:0]                   skip_reg;
    logic [LEN_W-1:0]                   skip_next;
    logic                               reported_reg;
    logic                               reported_next;
    logic [POSITION_BITS-1:0]           start_pos;
    logic                               win_match;
    logic                               pos_ok;
    logic                               hit;
    logic                               found_now;

    // Shift the new byte in and compare every window entry at once.
    always_comb
    begin
        win_match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k == 0)
            begin
                window_next[k] = data_byte;
            end
            else
            begin
                window_next[k] = window_reg[k-1];
            end
            if (aligned_pat[k] != WILDCARD && aligned_pat[k] != window_next[k])
            begin
                win_match = 1'b0;
            end
        end
    end

    // Match qualification, counting and the start offset.
    always_comb
    begin
        pos_ok    = pos_reg >= POSITION_BITS'(len_m1);
        hit       = !reported_reg && skip_reg == '0 && target != '0 && pos_ok && win_match;
        count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
        found_now = hit && count_inc == target;
        start_pos = pos_reg - POSITION_BITS'(len_m1);
    end

    // Next region state.
    always_comb
    begin
        count_next    = count_reg;
        skip_next     = skip_reg;
        reported_next = reported_reg;
        pos_next      = (pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;
        if (!reported_reg)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - 1'b1;
            end
            else if (hit)
            begin
                count_next = count_inc;
                if (found_now)
                begin
                    reported_next = 1'b1;
                end
                else
                begin
                    skip_next = len_m1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
            skip_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (end_of_region)
            begin
                window_reg   <= '0;
                pos_reg      <= '0;
                count_reg    <= '0;
                skip_reg     <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                window_reg   <= window_next;
                pos_reg      <= pos_next;
                count_reg    <= count_next;
                skip_reg     <= skip_next;
                reported_reg <= reported_next;
            end
        end
    end

    // A result comes from the requested match or from a region end without it.
    always_comb
    begin
        res_valid        = in_fire && (found_now || (end_of_region && !reported_reg));
        res.found        = found_now;
        res.match_offset = found_now ? OFFSET_W'(start_pos) : '0;
    end

endmodule

[design/wbps_outq.sv]
// Two-entry result queue that decouples the scan from the output handshake.
module wbps_outq
    import wbps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_valid,
    input  wbps_result_t wr_data,
    output logic         has_room,
    output logic         rd_valid,
    input  logic         rd_ready,
    output wbps_result_t rd_data
);

    wbps_result_t mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         rd_fire;

    assign rd_fire  = rd_valid && rd_ready;
    assign has_room = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_valid && !rd_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_valid && rd_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_valid)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_fire)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/wildcard_byte_pattern_scan_unit.sv]
// Top level of the wildcard byte pattern scan unit.
//
// Channel  Direction  Transaction    Payload
// s_*      in         one byte       s_tdata: data_byte; s_tlast: end_of_region
// m_*      out        one result     m_tdata: match_offset; m_tuser: found
// cfg_*    in         register write cfg_index: register index; cfg_data: value
//
// One byte is taken every cycle while s_tready is high; its result, if any,
// is in the output queue in the cycle after the transaction. The byte
// comparison is a single parallel pass over the window. Reset clears the
// window, region state and queue and loads the register defaults. s_tready
// drops while both result queue entries are full, also when m_tready is high.
module wildcard_byte_pattern_scan_unit
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OFFSET_W-1:0]   m_tdata,   // [31:0] match_offset
    output logic                  m_tuser,   // [0] found
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LEN_W-1:0]                   len_m1;
    logic [COUNT_W-1:0]                 target;
    logic [MAX_PATTERN-1:0][DATA_W-1:0] aligned_pat;
    logic                               in_fire;
    logic                               res_valid;
    wbps_result_t                       res;
    wbps_result_t                       out_res;

    assign in_fire = s_tvalid && s_tready;

    wbps_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .len_m1      (len_m1),
        .target      (target),
        .aligned_pat (aligned_pat)
    );

    wbps_scan #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS),
        .LEN_W         (LEN_W)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .data_byte     (s_tdata),
        .end_of_region (s_tlast),
        .len_m1        (len_m1),
        .target        (target),
        .aligned_pat   (aligned_pat),
        .res_valid     (res_valid),
        .res           (res)
    );

    wbps_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .has_room (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res)
    );

    assign m_tdata = out_res.match_offset;
    assign m_tuser = out_res.found;

endmodule

[bench/wbps_scan_checker.sv]
// Checker that predicts and compares every result of the wildcard byte pattern scan unit.
`timescale 1ns / 1ps

module wbps_scan_checker
    import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OFFSET_W-1:0]   m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int                 MAX_SHOWN    = 10;
    localparam logic [COUNT_W-1:0] COUNT_TOP    = '1;
    localparam logic [31:0]        POSITION_TOP = '1;

    // Shadow copy of the configuration registers.
    logic [LEN_FIELD_W-1:0] len_reg;
    logic [31:0]            target_reg;
    logic [CFG_DATA_W-1:0]  pattern_reg [PAT_WORDS];

    // Shadow copy of the region state.
    logic [DATA_W-1:0]      window [PAT_BYTES];
    logic [31:0]            position;
    logic [COUNT_W-1:0]     match_count;
    logic [4:0]             skip_left;
    logic                   reported;

    // Results still owed by the block, oldest first.
    wbps_result_t           owed_results [$];
    int                     errors;

    // Length in use: zero counts as one, anything above the window as the window.
    function automatic int active_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > PAT_BYTES)
            return PAT_BYTES;
        return int'(len_reg);
    endfunction

    // True when the newest len bytes of the window fit the pattern.
    function automatic logic window_hit(input int len);
        logic [DATA_W-1:0] p;
        for (int i = 0; i < len; i++)
        begin
            p = pattern_reg[i / BYTES_PER_WORD][(i % BYTES_PER_WORD) * DATA_W +: DATA_W];
            if (p != WILDCARD && p != window[len - 1 - i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_region();
        foreach (window[i])
            window[i] = '0;
        position    = '0;
        match_count = '0;
        skip_left   = '0;
        reported    = 1'b0;
    endtask

    // Advance the shadow state by one byte and queue the result it causes.
    task automatic scan_byte(input logic [DATA_W-1:0] b, input logic last);
        int           len;
        wbps_result_t res;
        len = active_len();
        for (int i = PAT_BYTES - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = b;
        if (!reported)
        begin
            if (skip_left != 0)
            begin
                skip_left = skip_left - 1'b1;
            end
            else if (target_reg != 0 && position >= 32'(len - 1) && window_hit(len))
            begin
                if (match_count != COUNT_TOP)
                    match_count = match_count + 1'b1;
                if (match_count == target_reg)
                begin
                    reported         = 1'b1;
                    res.found        = 1'b1;
                    res.match_offset = position - 32'(len - 1);
                    owed_results.insert(owed_results.size(), res);
                end
                else
                begin
                    skip_left = 5'(len - 1);
                end
            end
        end
        if (position != POSITION_TOP)
            position = position + 1'b1;
        // A region that closes without its match reports not found.
        if (last)
        begin
            if (!reported)
            begin
                res = '0;
                owed_results.insert(owed_results.size(), res);
            end
            clear_region();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        wbps_result_t want;
        if (!rst_n)
        begin
            len_reg    = 6'd1;
            target_reg = 32'd1;
            foreach (pattern_reg[i])
                pattern_reg[i] = '0;
            clear_region();
            owed_results.delete();
            errors = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PATTERN_LEN:    len_reg        = cfg_data[LEN_FIELD_W-1:0];
                    REG_TARGET_OCC:     target_reg     = cfg_data[31:0];
                    REG_PATTERN_BYTES0: pattern_reg[0] = cfg_data;
                    REG_PATTERN_BYTES1: pattern_reg[1] = cfg_data;
                    REG_PATTERN_BYTES2: pattern_reg[2] = cfg_data;
                    REG_PATTERN_BYTES3: pattern_reg[3] = cfg_data;
                    default: ;
                endcase
            end
            // Result transactions are compared before this edge's byte is scanned.
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("unexpected result: found %0b offset %0d", m_tuser, m_tdata);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (m_tuser !== want.found || m_tdata !== want.match_offset)
                    begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display("result mismatch: expected found %0b offset %0d, got %0b %0d",
                                     want.found, want.match_offset, m_tuser, m_tdata);
                    end
                end
            end
            // Byte transactions.
            if (s_tvalid && s_tready)
                scan_byte(s_tdata, s_tlast);
        end
        fail_count  <= errors;
        outstanding <= owed_results.size();
    end

endmodule

[bench/wildcard_byte_pattern_scan_unit_tb.sv]
// Stimulus and verdict for the wildcard byte pattern scan unit.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_unit_tb;
    import wbps_pkg::*;

    localparam int ITEMS        = 1800;
    localparam int CALM_ITEMS   = 300;
    localparam int SETTLE_WAIT  = 4;
    localparam int DRAIN_WAIT   = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata;    // [7:0] data_byte
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OFFSET_W-1:0]   m_tdata;    // [31:0] match_offset
    logic                  m_tuser;    // [0] found
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int bytes_sent = 0;
    int cycles     = 0;
    int idle_rate  = 0;
    int stall_rate = 0;
    int stall_left = 0;
    bit calm       = 1'b0;

    // Pattern currently loaded, kept to build matching regions.
    logic [PAT_BYTES*DATA_W-1:0] pat_bits = '0;
    int                          pat_len  = 1;

    wildcard_byte_pattern_scan_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wbps_scan_checker scan_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[wildcard_byte_pattern_scan_unit] ERROR");
            $finish;
        end
    end

    // Result receiver with random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!calm && stall_rate != 0 && $urandom_range(0, stall_rate) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Byte drawn from a small alphabet so that natural matches occur.
    function automatic logic [DATA_W-1:0] pick_symbol();
        case ($urandom_range(0, 4))
            0:       return 8'h41;
            1:       return 8'h42;
            2:       return 8'hFF;
            3:       return 8'h80;
            default: return 8'h00;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Load all registers; the block must be idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] len_word,
                             input logic [CFG_DATA_W-1:0] target_word,
                             input logic [PAT_BYTES*DATA_W-1:0] bytes_word);
        int v;
        write_reg(REG_PATTERN_LEN, len_word);
        write_reg(REG_TARGET_OCC, target_word);
        write_reg(REG_PATTERN_BYTES0, bytes_word[0*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_BYTES1, bytes_word[1*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_BYTES2, bytes_word[2*CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PATTERN_BYTES3, bytes_word[3*CFG_DATA_W +: CFG_DATA_W]);
        cfg_valid <= 1'b0;
        pat_bits = bytes_word;
        v = int'(len_word[LEN_FIELD_W-1:0]);
        pat_len = (v == 0) ? 1 : ((v > PAT_BYTES) ? PAT_BYTES : v);
    endtask

    // Wait until every owed result has come and the pipeline has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // One byte transaction, with an optional idle burst ahead of it.
    task automatic send_byte(input logic [DATA_W-1:0] b, input logic last);
        calm = (bytes_sent >= ITEMS - CALM_ITEMS);
        if (!calm && idle_rate != 0 && $urandom_range(0, idle_rate) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // A region mixing pattern instances, near misses and filler bytes.
    task automatic send_region(input int n, input bit close, input bit noisy);
        logic [DATA_W-1:0] seq [$];
        logic [DATA_W-1:0] b;
        int                k;
        int                r;
        while (seq.size() < n)
        begin
            r = $urandom_range(0, 9);
            if (noisy || r >= 8)
            begin
                seq.insert(seq.size(), 8'($urandom_range(0, 255)));
            end
            else if (r < 4)
            begin
                // One instance, sometimes spoiled in one byte.
                k = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, pat_len - 1)) : -1;
                for (int i = 0; i < pat_len; i++)
                begin
                    b = pat_bits[i*DATA_W +: DATA_W];
                    if (b == WILDCARD)
                        b = pick_symbol();
                    if (i == k)
                        b = b ^ 8'($urandom_range(1, 255));
                    seq.insert(seq.size(), b);
                end
            end
            else
            begin
                seq.insert(seq.size(), pick_symbol());
            end
        end
        foreach (seq[i])
            send_byte(seq[i], close && (i == seq.size() - 1));
    endtask

    // One random setting followed by a few regions under it.
    task automatic random_phase();
        logic [CFG_DATA_W-1:0]       len_word;
        logic [CFG_DATA_W-1:0]       target_word;
        logic [PAT_BYTES*DATA_W-1:0] bytes_word;
        int                          v;
        int                          eff;
        int                          regions;
        bit                          all_wild;
        case ($urandom_range(0, 19))
            0, 1:    v = PAT_BYTES;
            2:       v = 0;
            3:       v = $urandom_range(PAT_BYTES + 1, 63);
            4, 5:    v = $urandom_range(9, PAT_BYTES - 1);
            default: v = $urandom_range(1, 8);
        endcase
        eff = (v == 0) ? 1 : ((v > PAT_BYTES) ? PAT_BYTES : v);
        len_word = '0;
        if ($urandom_range(0, 3) == 0)
            len_word = {$urandom, $urandom};
        len_word[LEN_FIELD_W-1:0] = LEN_FIELD_W'(v);
        case ($urandom_range(0, 9))
            0:       target_word = 64'd0;
            1:       target_word = 64'hFFFF_FFFF;
            2, 3:    target_word = 64'($urandom_range(4, 8));
            default: target_word = 64'($urandom_range(1, 3));
        endcase
        all_wild = ($urandom_range(0, 15) == 0);
        for (int i = 0; i < PAT_BYTES; i++)
        begin
            if (i >= eff)
                bytes_word[i*DATA_W +: DATA_W] = 8'($urandom_range(0, 255));
            else if (all_wild || $urandom_range(0, 3) == 0)
                bytes_word[i*DATA_W +: DATA_W] = WILDCARD;
            else
                bytes_word[i*DATA_W +: DATA_W] = pick_symbol() | 8'h01;
        end
        configure(len_word, target_word, bytes_word);
        case ($urandom_range(0, 2))
            0:       idle_rate = 0;
            1:       idle_rate = 2;
            default: idle_rate = 8;
        endcase
        case ($urandom_range(0, 2))
            0:       stall_rate = 0;
            1:       stall_rate = 2;
            default: stall_rate = 6;
        endcase
        regions = $urandom_range(2, 6);
        for (int j = 0; j < regions; j++)
        begin
            send_region(($urandom_range(0, 9) < 7) ? $urandom_range(1, 40) : $urandom_range(41, 120),
                        (j != regions - 1) || ($urandom_range(0, 2) != 0),
                        $urandom_range(0, 4) == 0);
        end
        settle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PATTERN_LEN;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: one wildcard byte, so the first byte is reported and the
        // rest of the region, its final byte included, stays silent.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b1);
        settle();

        // Pattern with a wildcard in the middle: the first match is counted and the
        // second match lands on the final byte.
        configure(64'd3, 64'd2, 256'h41_00_41);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b1);
        settle();

        // Occurrence zero never finds anything.
        configure(64'd3, 64'd0, 256'h41_00_41);
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b1);
        settle();

        // Length zero acts as one.
        configure(64'd0, 64'd3, 256'hFF);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // All-ones registers: length clamps to the window, region too short.
        configure('1, '1, '1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        while (bytes_sent < ITEMS)
            random_phase();

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[wildcard_byte_pattern_scan_unit] OK");
        else
            $display("[wildcard_byte_pattern_scan_unit] ERROR");
        $finish;
    end

endmodule

[sim.f]
design/wbps_pkg.sv
design/wbps_cfg.sv
design/wbps_scan.sv
design/wbps_outq.sv
design/wildcard_byte_pattern_scan_unit.sv
bench/wbps_scan_checker.sv
bench/wildcard_byte_pattern_scan_unit_tb.sv
